// ----- design/uft_pkg.sv -----
// ----------------------------------------------------------------------------
// uft_pkg
// Shared types and constants for the UART frame serialiser.
// ----------------------------------------------------------------------------
package uft_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_SPB    = 2'd0;
    localparam logic [1:0] REG_IDLE   = 2'd1;
    localparam logic [1:0] REG_PARITY = 2'd2;

    // parity modes
    localparam logic [1:0] PAR_NONE  = 2'd0;
    localparam logic [1:0] PAR_EVEN  = 2'd1;
    localparam logic [1:0] PAR_ODD   = 2'd2;
    localparam logic [1:0] PAR_SPACE = 2'd3;

    // run positions inside one frame
    typedef logic [3:0] step_t;
    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_START  = 4'd1;
    localparam step_t STEP_D0     = 4'd2;
    localparam step_t STEP_D7     = 4'd9;
    localparam step_t STEP_PARITY = 4'd10;
    localparam step_t STEP_STOP   = 4'd11;

    // descriptor queue
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // configuration as seen by front and back (counts already clamped)
    typedef struct packed {
        logic [15:0] spb;
        logic [15:0] idle;
        logic [1:0]  parity_mode;
    } cfg_t;

    // classified frame
    typedef struct packed {
        logic       has_idle;
        logic       has_parity;
        logic       parity_bit;
        logic [7:0] data;
    } desc_t;

endpackage

// ----- design/uft_front.sv -----
// ----------------------------------------------------------------------------
// uft_front
// Accepts bytes and classifies them into frame descriptors.
// ----------------------------------------------------------------------------
module uft_front (
    input  logic          clk,
    input  logic          rst_n,
    input  uft_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    output logic          push,
    output uft_pkg::desc_t push_desc,
    input  logic          q_ready
);
    import uft_pkg::*;

    logic  desc_valid_reg, desc_valid_next;
    desc_t desc_reg, desc_next;
    logic  parity_calc;

    assign push      = desc_valid_reg && q_ready;
    assign in_ready  = !desc_valid_reg || q_ready;
    assign push_desc = desc_reg;

    always_comb
    begin
        case (cfg.parity_mode)
            PAR_NONE:  parity_calc = 1'b0;
            PAR_EVEN:  parity_calc = ^data_byte;
            PAR_ODD:   parity_calc = ~^data_byte;
            default:   parity_calc = 1'b0;   // space parity
        endcase
    end

    always_comb
    begin
        desc_valid_next = desc_valid_reg;
        desc_next       = desc_reg;
        if (push)
            desc_valid_next = 1'b0;
        if (in_valid && in_ready)
        begin
            desc_valid_next      = 1'b1;
            desc_next.has_idle   = (cfg.idle != 16'd0);
            desc_next.has_parity = (cfg.parity_mode != PAR_NONE);
            desc_next.parity_bit = parity_calc;
            desc_next.data       = data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            desc_valid_reg <= 1'b0;
        else
            desc_valid_reg <= desc_valid_next;
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

// ----- design/uft_queue.sv -----
// ----------------------------------------------------------------------------
// uft_queue
// Short descriptor FIFO between front and back.
// ----------------------------------------------------------------------------
module uft_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  uft_pkg::desc_t push_desc,
    output logic           q_ready,
    input  logic           pop,
    output logic           q_valid,
    output uft_pkg::desc_t head_desc
);
    import uft_pkg::*;

    desc_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign q_ready   = (count_reg != (QAW+1)'(QDEPTH));
    assign q_valid   = (count_reg != '0);
    assign head_desc = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

// ----- design/uft_back.sv -----
// ----------------------------------------------------------------------------
// uft_back
// Walks each frame descriptor and emits one run per cycle while out_ready does not hold the output register.
// ----------------------------------------------------------------------------
module uft_back (
    input  logic           clk,
    input  logic           rst_n,
    input  uft_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  uft_pkg::desc_t head_desc,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           line_level,
    output logic [15:0]    run_samples,
    output logic           frame_end
);
    import uft_pkg::*;

    step_t       step_reg, step_next;
    step_t       eff;
    logic        out_valid_reg, out_valid_next;
    logic        level_reg, level_next;
    logic [15:0] samples_reg, samples_next;
    logic        end_reg, end_next;
    logic        load;
    logic [2:0]  bit_idx;

    assign load        = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign line_level  = level_reg;
    assign run_samples = samples_reg;
    assign frame_end   = end_reg;

    // idle run skipped when the count was zero at classification
    assign eff     = (step_reg == STEP_IDLE && !head_desc.has_idle) ? STEP_START : step_reg;
    assign bit_idx = 3'(eff - STEP_D0);
    assign pop     = load && q_valid && (eff == STEP_STOP);

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        samples_next   = samples_reg;
        end_next       = end_reg;
        if (load)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                samples_next = cfg.spb;
                end_next     = 1'b0;
                case (eff)
                    STEP_IDLE:
                    begin
                        level_next   = 1'b1;
                        samples_next = cfg.idle;
                    end
                    STEP_START:  level_next = 1'b0;
                    STEP_PARITY: level_next = head_desc.parity_bit;
                    STEP_STOP:
                    begin
                        level_next = 1'b1;
                        end_next   = 1'b1;
                    end
                    default:     level_next = head_desc.data[bit_idx];
                endcase

                if (eff == STEP_STOP)
                    step_next = STEP_IDLE;
                else if (eff == STEP_D7 && !head_desc.has_parity)
                    step_next = STEP_STOP;
                else
                    step_next = eff + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg   <= level_next;
        samples_reg <= samples_next;
        end_reg     <= end_next;
    end

endmodule

// ----- design/uart_frame_serializer.sv -----
// ----------------------------------------------------------------------------
// uart_frame_serializer
// Turns each byte into its asynchronous serial frame as runs of line level.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, data_byte             | sink
//  out     | out_valid, out_ready, line_level,         | source
//          | run_samples, frame_end                    |
//  cfg     | cfg_we, cfg_index, cfg_wdata              | sink, write only
//
//  One run leaves per cycle while descriptors are queued and out_ready is high;
//  each byte gives 10 to 12 runs (idle run and parity run optional), set by
//  the back-end sequencer that walks one frame step a cycle. A byte's
//  transaction loads the front register; its first run then passes the
//  queue and the output register.
//  Reset is asynchronous and clears control state only; there is no
//  clearing pass. Front and back stall independently through a 4-deep
//  descriptor queue; the output register holds a valid run while out_ready is low.
//
module uart_frame_serializer #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        line_level,
    output logic [15:0] run_samples,
    output logic        frame_end
);
    import uft_pkg::*;

    // count registers are never wider than the 16-bit run field
    localparam int          CW    = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam logic [15:0] LIMIT = 16'((33'd1 << CW) - 33'd1);

    logic [CW-1:0] spb_reg, spb_next;
    logic [CW-1:0] idle_reg, idle_next;
    logic [1:0]    parity_reg, parity_next;
    logic [15:0]   wdata_clamped;

    cfg_t  cfg;
    logic  push, q_ready, q_valid, pop;
    desc_t push_desc, head_desc;

    // saturate writes to what the count registers hold
    assign wdata_clamped = (cfg_wdata > LIMIT) ? LIMIT : cfg_wdata;

    always_comb
    begin
        spb_next    = spb_reg;
        idle_next   = idle_reg;
        parity_next = parity_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SPB:
                begin
                    // zero bit length is taken as one sample
                    if (wdata_clamped == 16'd0)
                        spb_next = CW'(1);
                    else
                        spb_next = CW'(wdata_clamped);
                end
                REG_IDLE:   idle_next   = CW'(wdata_clamped);
                REG_PARITY: parity_next = cfg_wdata[1:0];
                default:    ;   // out-of-range index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg    <= CW'(LIMIT < 16'd16 ? LIMIT : 16'd16);
            idle_reg   <= '0;
            parity_reg <= PAR_NONE;
        end
        else
        begin
            spb_reg    <= spb_next;
            idle_reg   <= idle_next;
            parity_reg <= parity_next;
        end
    end

    assign cfg.spb         = 16'(spb_reg);
    assign cfg.idle        = 16'(idle_reg);
    assign cfg.parity_mode = parity_reg;

    // front: classify byte, compute parity
    uft_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .push      (push),
        .push_desc (push_desc),
        .q_ready   (q_ready)
    );

    // decoupling queue
    uft_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .head_desc (head_desc)
    );

    // back: one run per cycle into the output register while out_ready does not hold it
    uft_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .head_desc   (head_desc),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .line_level  (line_level),
        .run_samples (run_samples),
        .frame_end   (frame_end)
    );

endmodule
